FILE: rtl/core/fxa_pkg.sv
// shared types, constants and helpers for the q24.8 fixed-point alu
`default_nettype none
package fxa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 4;
  localparam int QW        = DATA_W + FRAC_BITS;
  localparam int PROD_W    = 2 * DATA_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MIN = 4'd4,
    OP_MAX = 4'd5,
    OP_INC = 4'd6,
    OP_DEC = 4'd7,
    OP_INT = 4'd8
  } op_e;

  // fields that ride alongside the divider
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] simple_res;
    logic              simple_ovf;
    logic              gt;
    logic              eq;
    logic              lt;
    logic [PROD_W-2:0] prod_mag;
    logic              neg;
    logic              dz;
  } side_t;

  // restoring divider state
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [QW-1:0]     nq;
    logic [DATA_W-1:0] den;
  } div_t;

  typedef struct packed {
    side_t side;
    div_t  div;
  } stage_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              ovf;
  } sat_t;

  // saturate a magnitude with sign to the signed data range
  function automatic sat_t sat_mag(input logic [PROD_W-1:0] m, input logic neg);
    sat_t              s;
    logic [PROD_W-1:0] lim;
    lim = neg ? (PROD_W'(1) << (DATA_W-1)) : ((PROD_W'(1) << (DATA_W-1)) - PROD_W'(1));
    if (m > lim) begin
      s.ovf = 1'b1;
      s.res = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      s.ovf = 1'b0;
      s.res = neg ? (-m[DATA_W-1:0]) : m[DATA_W-1:0];
    end
    return s;
  endfunction

  // saturate a signed value one bit wider than the data range
  function automatic sat_t sat_wide(input logic [DATA_W:0] x);
    sat_t s;
    if (x[DATA_W] != x[DATA_W-1]) begin
      s.ovf = 1'b1;
      s.res = x[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      s.ovf = 1'b0;
      s.res = x[DATA_W-1:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/fixed_point_q24_8_alu_core.sv
// top level of the q24.8 fixed-point alu pipeline
// Signed q24.8 ALU taking one word per cycle unless the output is stalled. Every word
// passes a fixed pipeline of 42 stages: one set-up stage (simple ops, compare flags,
// 32x32 magnitude multiply), 40 restoring-divider stages each yielding one quotient
// bit, and a final stage that rounds half away from zero, saturates and registers the
// result. The whole pipeline moves together and holds while the output word is stalled;
// in_stall_o is raised only then.
`default_nettype none
module fixed_point_q24_8_alu_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fxa_pkg::OP_W-1:0]          op_i,
  input  logic signed [fxa_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [fxa_pkg::DATA_W-1:0] operand_b_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [fxa_pkg::DATA_W-1:0] result_o,
  output logic                              a_greater_o,
  output logic                              a_equal_o,
  output logic                              a_less_o,
  output logic                              overflow_o,
  output logic                              div_by_zero_o
);

  logic            advance;
  logic            valid_s [fxa_pkg::QW+1];
  fxa_pkg::stage_t stage_s [fxa_pkg::QW+1];

  // pipeline moves unless a finished word is held at the output
  assign advance    = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~advance;

  fxa_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .valid_i     (in_valid_i),
    .op_i        (op_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (valid_s[0]),
    .stage_o     (stage_s[0])
  );

  // divider chain
  for (genvar i = 0; i < fxa_pkg::QW; i++) begin : g_div
    fxa_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (valid_s[i]),
      .stage_i (stage_s[i]),
      .valid_o (valid_s[i+1]),
      .stage_o (stage_s[i+1])
    );
  end

  fxa_final u_final (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .valid_i       (valid_s[fxa_pkg::QW]),
    .stage_i       (stage_s[fxa_pkg::QW]),
    .out_valid_o   (out_valid_o),
    .result_o      (result_o),
    .a_greater_o   (a_greater_o),
    .a_equal_o     (a_equal_o),
    .a_less_o      (a_less_o),
    .overflow_o    (overflow_o),
    .div_by_zero_o (div_by_zero_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/fxa_prep.sv
// first stage: simple ops, compare flags, magnitude product and divider set-up
`default_nettype none
module fxa_prep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [fxa_pkg::OP_W-1:0]          op_i,
  input  logic signed [fxa_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [fxa_pkg::DATA_W-1:0] operand_b_i,
  output logic                              valid_o,
  output fxa_pkg::stage_t                   stage_o
);

  logic [fxa_pkg::DATA_W-1:0] a_mag, b_mag;
  logic [fxa_pkg::PROD_W-1:0] prod;
  logic [fxa_pkg::DATA_W:0]   a_w, b_w;
  fxa_pkg::sat_t              simple;
  fxa_pkg::stage_t            stage_d, stage_q;
  logic                       valid_q;

  // magnitudes and sign-extended operands
  assign a_mag = operand_a_i[fxa_pkg::DATA_W-1] ? (-operand_a_i) : operand_a_i;
  assign b_mag = operand_b_i[fxa_pkg::DATA_W-1] ? (-operand_b_i) : operand_b_i;
  assign a_w   = {operand_a_i[fxa_pkg::DATA_W-1], operand_a_i};
  assign b_w   = {operand_b_i[fxa_pkg::DATA_W-1], operand_b_i};
  assign prod  = a_mag * b_mag;

  // results that need no multiplier or divider
  always_comb begin
    simple.res = '0;
    simple.ovf = 1'b0;
    case (op_i)
      fxa_pkg::OP_ADD: simple = fxa_pkg::sat_wide(a_w + b_w);
      fxa_pkg::OP_SUB: simple = fxa_pkg::sat_wide(a_w - b_w);
      fxa_pkg::OP_MIN: simple.res = (operand_a_i < operand_b_i) ? operand_a_i : operand_b_i;
      fxa_pkg::OP_MAX: simple.res = (operand_a_i > operand_b_i) ? operand_a_i : operand_b_i;
      fxa_pkg::OP_INC: simple = fxa_pkg::sat_wide(a_w + (fxa_pkg::DATA_W+1)'(1));
      fxa_pkg::OP_DEC: simple = fxa_pkg::sat_wide(a_w - (fxa_pkg::DATA_W+1)'(1));
      fxa_pkg::OP_INT: simple.res = operand_a_i >>> fxa_pkg::FRAC_BITS;
      default: ;
    endcase
  end

  // assemble the stage word
  always_comb begin
    stage_d.side.op         = op_i;
    stage_d.side.simple_res = simple.res;
    stage_d.side.simple_ovf = simple.ovf;
    stage_d.side.gt         = operand_a_i > operand_b_i;
    stage_d.side.eq         = operand_a_i == operand_b_i;
    stage_d.side.lt         = operand_a_i < operand_b_i;
    stage_d.side.prod_mag   = prod[fxa_pkg::PROD_W-2:0];
    stage_d.side.neg        = operand_a_i[fxa_pkg::DATA_W-1] ^ operand_b_i[fxa_pkg::DATA_W-1];
    stage_d.side.dz         = (op_i == fxa_pkg::OP_DIV) && (operand_b_i == '0);
    stage_d.div.rem         = '0;
    stage_d.div.nq          = {a_mag, {fxa_pkg::FRAC_BITS{1'b0}}};
    stage_d.div.den         = b_mag;
  end

  // valid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

FILE: rtl/core/fxa_div_stage.sv
// one restoring division step, one quotient bit per stage
`default_nettype none
module fxa_div_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  fxa_pkg::stage_t stage_i,
  output logic            valid_o,
  output fxa_pkg::stage_t stage_o
);

  logic [fxa_pkg::DATA_W:0] trial, dif;
  logic                     qbit;
  fxa_pkg::stage_t          stage_d, stage_q;
  logic                     valid_q;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {stage_i.div.rem, stage_i.div.nq[fxa_pkg::QW-1]};
  assign dif   = trial - {1'b0, stage_i.div.den};
  assign qbit  = ~dif[fxa_pkg::DATA_W];

  always_comb begin
    stage_d         = stage_i;
    stage_d.div.rem = qbit ? dif[fxa_pkg::DATA_W-1:0] : trial[fxa_pkg::DATA_W-1:0];
    stage_d.div.nq  = {stage_i.div.nq[fxa_pkg::QW-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
`default_nettype wire

FILE: rtl/core/fxa_final.sv
// last stage: rounding, saturation and result select into the output register
`default_nettype none
module fxa_final (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  fxa_pkg::stage_t                   stage_i,
  output logic                              out_valid_o,
  output logic signed [fxa_pkg::DATA_W-1:0] result_o,
  output logic                              a_greater_o,
  output logic                              a_equal_o,
  output logic                              a_less_o,
  output logic                              overflow_o,
  output logic                              div_by_zero_o
);

  logic [fxa_pkg::PROD_W-1:0] mul_r, div_r;
  logic                       round_up;
  fxa_pkg::sat_t              sel;
  logic                       valid_q;
  logic [fxa_pkg::DATA_W-1:0] result_q;
  logic                       gt_q, eq_q, lt_q, ovf_q, dz_q;

  // round half away from zero on magnitudes
  assign mul_r = ({1'b0, stage_i.side.prod_mag}
                 + (fxa_pkg::PROD_W'(1) << (fxa_pkg::FRAC_BITS-1))) >> fxa_pkg::FRAC_BITS;
  assign round_up = {stage_i.div.rem, 1'b0} >= {1'b0, stage_i.div.den};
  assign div_r    = fxa_pkg::PROD_W'(stage_i.div.nq) + fxa_pkg::PROD_W'(round_up);

  // result select
  always_comb begin
    sel.res = stage_i.side.simple_res;
    sel.ovf = stage_i.side.simple_ovf;
    case (stage_i.side.op)
      fxa_pkg::OP_MUL: sel = fxa_pkg::sat_mag(mul_r, stage_i.side.neg);
      fxa_pkg::OP_DIV: begin
        if (stage_i.side.dz) begin
          sel.res = '0;
          sel.ovf = 1'b0;
        end else begin
          sel = fxa_pkg::sat_mag(div_r, stage_i.side.neg);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= sel.res;
      ovf_q    <= sel.ovf;
      gt_q     <= stage_i.side.gt;
      eq_q     <= stage_i.side.eq;
      lt_q     <= stage_i.side.lt;
      dz_q     <= stage_i.side.dz;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_o      = result_q;
  assign a_greater_o   = gt_q;
  assign a_equal_o     = eq_q;
  assign a_less_o      = lt_q;
  assign overflow_o    = ovf_q;
  assign div_by_zero_o = dz_q;

endmodule
`default_nettype wire

FILE: rtl/core/fxa_checker.sv
// port-level checks for the q24.8 fixed-point alu, bound to the top level
`default_nettype none
module fxa_assert (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [fxa_pkg::DATA_W-1:0] result_o,
  input logic                       a_greater_o,
  input logic                       a_equal_o,
  input logic                       a_less_o,
  input logic                       overflow_o,
  input logic                       div_by_zero_o
);

  // input stalls only while an output word is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output word");

  // exactly one compare flag per word
  a_flags_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({a_greater_o, a_equal_o, a_less_o}))
    else $error("compare flags not one-hot");

  // divide by zero never reports overflow
  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_by_zero_o) |-> (!overflow_o && result_o == '0))
    else $error("divide by zero with overflow or nonzero result");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_o)))
    else $error("stalled output word changed");

endmodule

bind fixed_point_q24_8_alu_core fxa_assert u_fxa_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_o      (result_o),
  .a_greater_o   (a_greater_o),
  .a_equal_o     (a_equal_o),
  .a_less_o      (a_less_o),
  .overflow_o    (overflow_o),
  .div_by_zero_o (div_by_zero_o)
);
`default_nettype wire

FILE: tb/sv/fxa_checker.sv
// checker for the q24.8 fixed-point alu: predicts each result word and compares it
`timescale 1ns / 1ps
module fxa_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [fxa_pkg::OP_W-1:0]          op_i,
  input  logic signed [fxa_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [fxa_pkg::DATA_W-1:0] operand_b_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [fxa_pkg::DATA_W-1:0] result_i,
  input  logic                              a_greater_i,
  input  logic                              a_equal_i,
  input  logic                              a_less_i,
  input  logic                              overflow_i,
  input  logic                              div_by_zero_i,
  output int                                fail_cnt_o,
  output int                                pending_o,
  output int                                words_seen_o
);

  typedef struct packed {
    logic [31:0] res;
    logic        gt;
    logic        eq;
    logic        lt;
    logic        ovf;
    logic        dz;
  } alu_word_t;

  alu_word_t expected_words[$];
  int        fail_cnt = 0;
  int        pending = 0;
  int        words_seen = 0;

  // saturate an exact value to the signed 32-bit range
  function automatic logic [32:0] saturate(input longint x);
    if (x > 64'sd2147483647) return {1'b1, 32'h7fffffff};
    if (x < -64'sd2147483648) return {1'b1, 32'h80000000};
    return {1'b0, x[31:0]};
  endfunction

  // exact arithmetic with rounding half away from zero
  function automatic alu_word_t predict_alu(input logic [3:0] op, input longint a,
                                            input longint b);
    alu_word_t   w;
    logic [32:0] s;
    longint      p, q, r;
    longint unsigned m, num, den;
    s = '0;
    w = '0;
    w.gt = a > b;
    w.eq = a == b;
    w.lt = a < b;
    case (op)
      fxa_pkg::OP_ADD: s = saturate(a + b);
      fxa_pkg::OP_SUB: s = saturate(a - b);
      fxa_pkg::OP_MUL: begin
        p = a * b;
        m = p < 0 ? -p : p;
        m = (m + (64'd1 << (fxa_pkg::FRAC_BITS - 1))) >> fxa_pkg::FRAC_BITS;
        s = saturate(p < 0 ? -longint'(m) : longint'(m));
      end
      fxa_pkg::OP_DIV: begin
        if (b == 0) begin
          w.dz = 1'b1;
        end else begin
          num = (a < 0 ? -a : a) << fxa_pkg::FRAC_BITS;
          den = b < 0 ? -b : b;
          q = num / den;
          r = num % den;
          if (2 * r >= den) q++;
          s = saturate(((a < 0) != (b < 0)) ? -q : q);
        end
      end
      fxa_pkg::OP_MIN: s = {1'b0, (a < b) ? a[31:0] : b[31:0]};
      fxa_pkg::OP_MAX: s = {1'b0, (a > b) ? a[31:0] : b[31:0]};
      fxa_pkg::OP_INC: s = saturate(a + 1);
      fxa_pkg::OP_DEC: s = saturate(a - 1);
      fxa_pkg::OP_INT: s = {1'b0, 32'(a >>> fxa_pkg::FRAC_BITS)};
      default: s = '0;
    endcase
    w.res = s[31:0];
    w.ovf = s[32];
    return w;
  endfunction

  // record accepted inputs, compare accepted outputs
  always @(posedge clk_i) begin
    alu_word_t got, exp_w;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        expected_words.push_back(predict_alu(op_i, longint'(operand_a_i),
                                             longint'(operand_b_i)));
      if (out_valid_i && !out_stall_i) begin
        got = {result_i, a_greater_i, a_equal_i, a_less_i, overflow_i, div_by_zero_i};
        words_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, got);
          fail_cnt++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            $display("%0t: result expected %h actual %h,", $time, exp_w.res, got.res);
            $display("  flags gt/eq/lt/ovf/dz expected %b actual %b",
                     exp_w[4:0], got[4:0]);
            fail_cnt++;
          end
        end
      end
    end
    pending = expected_words.size();
  end

  assign fail_cnt_o   = fail_cnt;
  assign pending_o    = pending;
  assign words_seen_o = words_seen;
endmodule

FILE: tb/sv/tb_fixed_point_q24_8_alu_core.sv
// testbench top for the q24.8 fixed-point alu: stimulus, stalls and verdict
`timescale 1ns / 1ps
module tb_fixed_point_q24_8_alu_core;

  logic        clk_i = 1'b0, rst_ni = 1'b0;
  logic        in_valid_i = 1'b0, out_stall_i = 1'b0;
  logic [3:0]  op_i = '0;
  logic signed [31:0] operand_a_i = '0, operand_b_i = '0;
  logic        in_stall_o, out_valid_o;
  logic signed [31:0] result_o;
  logic        a_greater_o, a_equal_o, a_less_o, overflow_o, div_by_zero_o;
  int          fail_cnt, pending, words_seen, cycles;
  int          send_idle_pct = 16, recv_idle_pct = 72;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  fixed_point_q24_8_alu_core u_top (.*);

  fxa_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .operand_a_i,
    .operand_b_i, .out_valid_i(out_valid_o), .out_stall_i, .result_i(result_o),
    .a_greater_i(a_greater_o), .a_equal_i(a_equal_o), .a_less_i(a_less_o),
    .overflow_i(overflow_o), .div_by_zero_i(div_by_zero_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .words_seen_o(words_seen)
  );

  // receiver stall, drawn each falling edge
  always @(negedge clk_i)
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // present one word and hold it until accepted
  task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // operand biased toward edges and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff - $urandom_range(2);
      1: return 32'h80000000 + $urandom_range(2);
      2: return $urandom_range(2) - 1;
      3, 4: return 32'($signed($urandom_range(8191)) - 4096);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[6];
    edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00000180};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: every op on the range ends, zero divisor, unused code
    for (int i = 0; i < 9; i++) begin
      send_word(4'(i), edge_vals[i % 6], edge_vals[(i + 1) % 6]);
      send_word(4'(i), edge_vals[(i + 3) % 6], edge_vals[(i + 4) % 6]);
    end
    send_word(fxa_pkg::OP_DIV, 32'h00000500, 32'h0);
    send_word(fxa_pkg::OP_DIV, 32'h80000000, 32'hffffffff);
    send_word(fxa_pkg::OP_MUL, 32'h80000000, 32'h80000000);
    send_word(fxa_pkg::OP_MUL, 32'hffffff80, 32'h00000001);
    send_word(fxa_pkg::OP_INT, 32'hfffffe80, 32'h0);
    send_word(4'd15, 32'h5, 32'h5);
    send_word(4'd9, 32'h0, 32'h1);
    // random phases with changing idle pressure
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 16 : 0;
      for (int n = 0; n < 350; n++)
        send_word(($urandom_range(15) == 0) ? 4'($urandom_range(15, 9))
                                            : 4'($urandom_range(8)),
                  pick_operand(), ($urandom_range(19) == 0) ? 32'h0 : pick_operand());
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered all nine ops plus unused codes on edge, small and random operands,");
    $display("%0d result words checked under three idle mixes", words_seen);
    if (fail_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/fxa_pkg.sv
rtl/core/fxa_prep.sv
rtl/core/fxa_div_stage.sv
rtl/core/fxa_final.sv
rtl/core/fixed_point_q24_8_alu_core.sv
rtl/core/fxa_checker.sv
tb/sv/fxa_checker.sv
tb/sv/tb_fixed_point_q24_8_alu_core.sv
